// ===== rtl/tks_pkg.sv =====
// Package with the shared types and constants of the top-k smallest selector.
package tks_pkg;

  localparam int SLOTS       = 40;
  localparam int INDEX_WIDTH = 20;
  localparam int DIST_W      = 32;
  localparam int RANK_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Fixed widths of the stream fields.
  localparam int RANK_FW  = 6;
  localparam int INDEX_FW = 20;
  localparam int IN_DW    = 56;
  localparam int OUT_DW   = 64;

  localparam logic signed [DIST_W-1:0] EMPTY_DIST = {1'b0, {(DIST_W-1){1'b1}}};

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic [INDEX_WIDTH-1:0]   idx;
    logic                     filled;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '{distance: EMPTY_DIST, idx: '0, filled: 1'b0};

endpackage

// ===== rtl/tks_cell.sv =====
// One slot of the sorted list: compares the incoming distance and shifts down.
module tks_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            clr_i,
  input  tks_pkg::entry_t new_i,
  input  logic            up_lt_i,
  input  tks_pkg::entry_t up_i,
  output logic            lt_o,
  output tks_pkg::entry_t eff_o,
  output tks_pkg::entry_t next_o
);
  import tks_pkg::*;

  entry_t slot_q, slot_d, eff;

  // A new query sees every slot as empty.
  assign eff   = clr_i ? EMPTY_ENTRY : slot_q;
  assign lt_o  = $signed(new_i.distance) < $signed(eff.distance);
  assign eff_o = eff;

  always_comb begin
    priority if (up_lt_i) begin
      next_o = up_i;
    end else if (lt_o) begin
      next_o = new_i;
    end else begin
      next_o = eff;
    end
  end

  assign slot_d = en_i ? next_o : slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= EMPTY_ENTRY;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

// ===== rtl/tks_emit.sv =====
// Snapshot row that holds the ranked list and shifts it out one rank per transfer.
module tks_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  tks_pkg::entry_t snap_i [tks_pkg::SLOTS],
  input  logic            pop_i,
  output logic            valid_o,
  output tks_pkg::entry_t head_o,
  output logic [tks_pkg::RANK_W-1:0] rank_o,
  output logic            final_o
);
  import tks_pkg::*;

  entry_t              row_q [SLOTS];
  entry_t              row_d [SLOTS];
  logic [RANK_W-1:0]   rank_q, rank_d;
  logic                busy_q, busy_d;

  assign valid_o = busy_q;
  assign head_o  = row_q[0];
  assign rank_o  = rank_q;
  assign final_o = (rank_q == RANK_W'(SLOTS - 1));

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if (load_i) begin
        row_d[i] = snap_i[i];
      end else if (pop_i && (i < SLOTS - 1)) begin
        row_d[i] = row_q[(i < SLOTS - 1) ? i + 1 : i];
      end else begin
        row_d[i] = row_q[i];
      end
    end
  end

  always_comb begin
    priority if (load_i) begin
      rank_d = '0;
      busy_d = 1'b1;
    end else if (pop_i) begin
      rank_d = rank_q + RANK_W'(1);
      busy_d = busy_q && !final_o;
    end else begin
      rank_d = rank_q;
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      row_q[i] <= row_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
      busy_q <= 1'b0;
    end else begin
      rank_q <= rank_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ===== rtl/top_k_smallest_selector.sv =====
// Top level of the top-k smallest selector: insertion cell chain and ranked output row.
//
// Usage: candidates arrive on the slave stream, one per transfer. tdata carries the
// signed Q16.16 distance and the candidate index, tuser marks the first candidate of a
// query (the list is cleared before it is inserted) and tlast the final candidate.
// The list is a chain of cells, one per slot; every cell compares the incoming
// distance with its own in parallel and the larger entries shift down by one slot,
// so a candidate is taken in every cycle unless a tlast candidate has to wait for the
// output row. A tie keeps the earlier entry ahead.
// After a transfer with tlast, the ranked list is copied into an output row in the
// same cycle and appears on the master stream in the following cycle, rank 0 first, one rank
// per transfer: SLOTS transfers, the final one with tlast. tuser marks a filled slot;
// an empty slot reads as the largest distance with index zero.
// Candidates of the next query keep streaming in while the list is being sent. Only
// a further tlast candidate waits (tready low) until the final rank of the previous
// list is taken; it may be accepted in that same cycle. When the receiver stalls, the
// current rank holds on the master stream.
// Reset empties every slot and drops any list that is being sent.
module top_k_smallest_selector (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // Fields from bit 0: distance[31:0], cand_index[51:32], zero fill.
  input  logic [tks_pkg::IN_DW-1:0]   s_axis_tdata_i,
  // Fields from bit 0: first.
  input  logic                        s_axis_tuser_i,
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // Fields from bit 0: rank[5:0], best_distance[37:6], best_index[57:38], zero fill.
  output logic [tks_pkg::OUT_DW-1:0]  m_axis_tdata_o,
  // Fields from bit 0: filled.
  output logic                        m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);
  import tks_pkg::*;

  entry_t            new_entry;
  logic              in_fire;
  logic              out_fire;
  logic              emit_final;
  logic              emit_valid;
  entry_t            head;
  logic [RANK_W-1:0] rank;
  logic              lt   [SLOTS];
  entry_t            eff  [SLOTS];
  entry_t            nxt  [SLOTS];

  assign new_entry.distance = $signed(s_axis_tdata_i[DIST_W-1:0]);
  assign new_entry.idx      = INDEX_WIDTH'(s_axis_tdata_i[DIST_W +: INDEX_FW]);
  assign new_entry.filled   = 1'b1;

  assign out_fire = emit_valid && m_axis_tready_i;

  // Only a list-ending candidate has to wait for the output row to be free.
  assign s_axis_tready_o = !(emit_valid && !(out_fire && emit_final) && s_axis_tlast_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Slot chain: each cell sees the compare result and current entry of the slot above.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    tks_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (in_fire),
      .clr_i   (s_axis_tuser_i),
      .new_i   (new_entry),
      .up_lt_i ((g == 0) ? 1'b0 : lt[(g == 0) ? 0 : g - 1]),
      .up_i    ((g == 0) ? EMPTY_ENTRY : eff[(g == 0) ? 0 : g - 1]),
      .lt_o    (lt[g]),
      .eff_o   (eff[g]),
      .next_o  (nxt[g])
    );
  end

  // The output row captures the list as it stands after the final insert.
  tks_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_fire && s_axis_tlast_i),
    .snap_i  (nxt),
    .pop_i   (out_fire),
    .valid_o (emit_valid),
    .head_o  (head),
    .rank_o  (rank),
    .final_o (emit_final)
  );

  assign m_axis_tvalid_o = emit_valid;
  assign m_axis_tdata_o  = {(OUT_DW - RANK_FW - DIST_W - INDEX_FW)'(0),
                            INDEX_FW'(head.idx), head.distance, RANK_FW'(rank)};
  assign m_axis_tuser_o  = head.filled;
  assign m_axis_tlast_o  = emit_final;

endmodule

// ===== rtl/tks_checker.sv =====
// Port-level checker for the top-k smallest selector, bound to the top level.
module tks_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic                        s_axis_tlast_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [tks_pkg::OUT_DW-1:0]  m_axis_tdata_o,
  input logic                        m_axis_tuser_o,
  input logic                        m_axis_tlast_o
);
  import tks_pkg::*;

  logic out_fire;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result withdrawn while stalled");

  // A list starts at rank zero right after its final candidate is taken.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=>
      m_axis_tvalid_o && (m_axis_tdata_o[5:0] == 6'd0))
    else $error("ranked list did not start at rank zero");

  // Ranks follow each other without gaps within one list.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (m_axis_tdata_o[5:0] == $past(m_axis_tdata_o[5:0]) + 6'd1))
    else $error("rank sequence broken");

  // The list ends on the final slot.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[5:0] == RANK_FW'(SLOTS - 1))
    else $error("tlast on a rank other than the final slot");

  // An empty slot reports the largest distance.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[37:6] == EMPTY_DIST)
    else $error("empty slot with a real distance");

endmodule

bind top_k_smallest_selector tks_checker u_tks_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== sim/tb_top_k_smallest_selector.sv =====
// Self-checking testbench for the top-k smallest selector with a built-in list predictor.
`timescale 1ns / 100ps

module tb_top_k_smallest_selector;

  localparam int SLOTS = tks_pkg::SLOTS;
  localparam int RX_STALL_CYCLES = 300;
  localparam int RANDOM_ITEMS = 88;

  // One candidate as the sender offers it, with its pacing controls.
  typedef struct {
    logic signed [31:0] distance;
    logic [19:0]        idx;
    bit                 first;
    bit                 last;
    bit                 drain;    // wait until every ranked result has arrived
    bit                 arm;      // start the long receiver hold-off
    int unsigned        gap;
  } cand_t;

  // One expected rank of an emitted list.
  typedef struct {
    logic [5:0]         rank;
    logic signed [31:0] distance;
    logic [19:0]        idx;
    logic               filled;
    logic               tail;
  } ranked_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [tks_pkg::IN_DW-1:0]    s_axis_tdata_i = '0;
  logic                         s_axis_tuser_i = 1'b0;
  logic                         s_axis_tlast_i = 1'b0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [tks_pkg::OUT_DW-1:0]   m_axis_tdata_o;
  logic                         m_axis_tuser_o;
  logic                         m_axis_tlast_o;

  top_k_smallest_selector u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cand_t   pending_q[$];
  ranked_t ranked_q[$];

  // Predicted contents of the sorted list.
  logic signed [31:0] list_dist[SLOTS];
  logic [19:0]        list_idx[SLOTS];
  logic               list_filled[SLOTS];

  int  err_cnt = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  bit  drain_next = 1'b0;
  bit  arm_next = 1'b0;
  bit  stall_arm = 1'b0;
  bit  rx_hold = 1'b0;
  int  gap_left = -1;
  int  rx_wait = 0;
  int  rx_left = 0;
  bit  rx_steady = 1'b0;

  function automatic void clear_list();
    for (int k = 0; k < SLOTS; k++) begin
      list_dist[k]   = tks_pkg::EMPTY_DIST;
      list_idx[k]    = '0;
      list_filled[k] = 1'b0;
    end
  endfunction

  // Insert one accepted candidate; a closing candidate queues the whole ranked list.
  function automatic void insert_candidate(logic signed [31:0] d, logic [19:0] ix,
                                           bit first, bit last);
    int      pos;
    ranked_t r;
    if (first) clear_list();
    pos = SLOTS;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if ($signed(d) < $signed(list_dist[k])) pos = k;
    end
    if (pos < SLOTS) begin
      for (int k = SLOTS - 1; k > pos; k--) begin
        list_dist[k]   = list_dist[k-1];
        list_idx[k]    = list_idx[k-1];
        list_filled[k] = list_filled[k-1];
      end
      list_dist[pos]   = d;
      list_idx[pos]    = ix;
      list_filled[pos] = 1'b1;
    end
    if (last) begin
      for (int k = 0; k < SLOTS; k++) begin
        r.rank     = k[5:0];
        r.distance = list_dist[k];
        r.idx      = list_idx[k];
        r.filled   = list_filled[k];
        r.tail     = (k == SLOTS - 1);
        ranked_q.push_back(r);
      end
    end
  endfunction

  function automatic void report_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Mostly random codes, with the extremes and a narrow band that produces ties.
  function automatic logic signed [31:0] pick_distance();
    int v;
    case ($urandom_range(0, 9))
      0: return tks_pkg::EMPTY_DIST;
      1: return 32'sh8000_0000;
      2, 3, 4: begin
        v = $urandom_range(0, 15);
        return (v - 8) * 65536;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_cand(logic signed [31:0] d, logic [19:0] ix, bit first,
                                     bit last, int unsigned gap);
    cand_t c;
    c.distance = d;
    c.idx      = ix;
    c.first    = first;
    c.last     = last;
    c.gap      = gap;
    c.drain    = drain_next;
    c.arm      = arm_next;
    drain_next = 1'b0;
    arm_next   = 1'b0;
    pending_q.push_back(c);
  endfunction

  // A tidy query opens with first and closes with last; an untidy one sets flags at random.
  function automatic void queue_query(int n, bit tidy, bit steady);
    bit f;
    bit l;
    for (int i = 0; i < n; i++) begin
      f = tidy ? (i == 0) : ($urandom_range(0, 4) == 0);
      l = tidy ? (i == n - 1) : ($urandom_range(0, 5) == 0);
      queue_cand(pick_distance(), 20'($urandom), f, l, steady ? 0 : $urandom_range(0, 5));
    end
  endfunction

  // Sender: inputs change on the falling edge only.
  always @(negedge clk_i) begin
    cand_t c;
    bit    v;
    v = s_axis_tvalid_i;
    if (v && in_taken) begin
      v = 1'b0;
      gap_left = -1;
    end
    if (!v && rst_ni && pending_q.size() != 0 &&
        !(pending_q[0].drain && ranked_q.size() != 0)) begin
      if (gap_left < 0) gap_left = pending_q[0].gap;
      if (gap_left == 0) begin
        c = pending_q.pop_front();
        s_axis_tdata_i <= {4'b0, c.idx, c.distance};
        s_axis_tuser_i <= c.first;
        s_axis_tlast_i <= c.last;
        if (c.arm) stall_arm <= 1'b1;
        v = 1'b1;
        gap_left = -1;
      end else begin
        gap_left--;
      end
    end
    s_axis_tvalid_i <= v;
  end

  // Receiver: a random wait per result, with stretches of steady acceptance.
  always @(negedge clk_i) begin
    if (out_taken) begin
      if (rx_left == 0) begin
        rx_steady = ($urandom_range(0, 2) == 0);
        rx_left   = $urandom_range(40, 120);
      end else begin
        rx_left--;
      end
      rx_wait = rx_steady ? 0 : $urandom_range(0, 5);
    end
    if (rx_wait != 0) begin
      rx_wait--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !rx_hold;
    end
  end

  // Long hold-off on the master side once a list is being sent, so that
  // further closing candidates back up against the input.
  initial begin
    wait (stall_arm);
    while (!m_axis_tvalid_o) @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (RX_STALL_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  // Monitor: both streams are sampled on the rising edge.
  always @(posedge clk_i) begin
    ranked_t e;
    ranked_t got;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_taken = 1'b1;
        insert_candidate(s_axis_tdata_i[31:0], s_axis_tdata_i[51:32],
                         s_axis_tuser_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_taken    = 1'b1;
        got.rank     = m_axis_tdata_o[5:0];
        got.distance = m_axis_tdata_o[37:6];
        got.idx      = m_axis_tdata_o[57:38];
        got.filled   = m_axis_tuser_o;
        got.tail     = m_axis_tlast_o;
        if (ranked_q.size() == 0) begin
          report_error($sformatf("unexpected rank %0d dist %h idx %h", got.rank,
                                 got.distance, got.idx));
        end else begin
          e = ranked_q.pop_front();
          if (got.rank !== e.rank || got.distance !== e.distance || got.idx !== e.idx ||
              got.filled !== e.filled || got.tail !== e.tail) begin
            report_error($sformatf(
              "exp rank %0d dist %h idx %h filled %b last %b, got %0d %h %h %b %b",
              e.rank, e.distance, e.idx, e.filled, e.tail,
              got.rank, got.distance, got.idx, got.filled, got.tail));
          end
        end
      end
    end
  end

  initial begin
    int rand_items;
    int n;

    clear_list();

    // Directed part. The first list comes straight from reset, without a first flag.
    queue_cand(32'sh0003_0000, 20'h00007, 1'b0, 1'b1, 0);
    queue_cand(32'sh8000_0000, 20'hFFFFF, 1'b1, 1'b1, 2);    // first and last together
    drain_next = 1'b1;
    queue_cand(tks_pkg::EMPTY_DIST, 20'h00001, 1'b1, 1'b0, 0); // never inserted
    queue_cand(32'sh0000_0000, 20'h00002, 1'b0, 1'b0, 1);
    queue_cand(32'sh0000_0000, 20'h00003, 1'b0, 1'b0, 0);    // tie keeps the earlier ahead
    queue_cand(-32'sd1,        20'h00004, 1'b0, 1'b0, 3);
    queue_cand(32'sh7FFF_FFFE, 20'h00005, 1'b0, 1'b0, 0);
    queue_cand(tks_pkg::EMPTY_DIST, 20'h00006, 1'b0, 1'b0, 5);
    queue_cand(32'sh8000_0000, 20'h00000, 1'b0, 1'b1, 0);
    queue_cand(32'sh0001_0000, 20'hAAAAA, 1'b0, 1'b1, 4);    // list carries over
    queue_cand(32'sh0005_0000, 20'h55555, 1'b1, 1'b0, 0);
    queue_cand(32'sh0006_0000, 20'h00009, 1'b1, 1'b1, 1);    // second first drops the first

    // Random part: a long query overflows the list and drops its tail entries.
    drain_next = 1'b1;
    n = $urandom_range(42, 48);
    queue_query(n, 1'b1, 1'b0);
    rand_items = n;

    // Short closing queries back to back while the receiver holds off.
    drain_next = 1'b1;
    arm_next   = 1'b1;
    for (int q = 0; q < 8; q++) begin
      n = $urandom_range(1, 3);
      queue_query(n, 1'b1, 1'b1);
      rand_items += n;
    end

    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(41, 46);
        1, 2: n = $urandom_range(1, 6);
        default: n = $urandom_range(1, 10);
      endcase
      if ($urandom_range(0, 5) == 0) drain_next = 1'b1;
      queue_query(n, (n > 6) || ($urandom_range(0, 2) != 0), $urandom_range(0, 3) == 0);
      rand_items += n;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || s_axis_tvalid_i || ranked_q.size() != 0)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    if (err_cnt == 0 && ranked_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
